// File: hw/rtl/argb_blend_pkg.sv
`timescale 1ns / 1ps

package argb_blend_pkg;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_W = 4;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLEND_MODE   = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GLOBAL_ALPHA = 4'd1;

   // Blend mode codes; the remaining codes pass the destination through
   localparam logic [2:0] MODE_ARGB_OVER_ARGB  = 3'd0;
   localparam logic [2:0] MODE_RGB_OVER_ARGB   = 3'd1;
   localparam logic [2:0] MODE_ARGB_OVER_RGB   = 3'd2;
   localparam logic [2:0] MODE_TRANS_KEEP_ALPHA = 3'd3;
   localparam logic [2:0] MODE_ADD_ALPHA       = 3'd4;

   // Reciprocal table for renormalisation: 0x10000 / n for n = 1 .. 256
   localparam int unsigned RECIP_W         = 17;
   localparam int unsigned RECIP_DEPTH     = 256;
   localparam int unsigned RECIP_NUMERATOR = 32'h0001_0000;

   // What a word still needs once it leaves a stage
   typedef enum logic [1:0] {
      KIND_PASS = 2'd0,   // final pixel already known
      KIND_CORE = 2'd1,   // combined-alpha blend with renormalisation
      KIND_MIX  = 2'd2    // plain lane mix
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] pass_pix;
      logic [23:0] src_rgb;
      logic [23:0] dst_rgb;
      logic [8:0]  weight;
      logic [8:0]  dst_weight;
      logic [7:0]  mix_alpha;
   } s1_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] pass_pix;
      logic [23:0] src_rgb;
      logic [23:0] dst_rgb;
      logic [8:0]  weight;
      logic [23:0] lane_rb;
      logic [15:0] lane_g;
      logic [7:0]  fa_m1;
      logic [7:0]  mix_alpha;
   } s2_type;

   typedef struct packed {
      kind_type           kind;
      logic [31:0]        pass_pix;
      logic [23:0]        rb;
      logic [15:0]        g;
      logic [RECIP_W-1:0] recip;
      logic [7:0]         fa_m1;
   } s3_type;

endpackage

// File: hw/rtl/argb_blend_weight.sv
`timescale 1ns / 1ps

module argb_blend_weight
   import argb_blend_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  logic        valid_in,
   input  logic [31:0] src_pixel,
   input  logic [31:0] dst_pixel,
   input  logic [2:0]  blend_mode,
   input  logic [7:0]  global_alpha,
   output logic        valid_out,
   output s1_type      data_out
);

   logic        valid_ff;
   s1_type      data_ff;
   s1_type      data_in;
   logic [7:0]  src_a;
   logic [7:0]  dst_a;
   logic [8:0]  ga_inc;
   logic [15:0] eff_prod;
   logic [7:0]  eff_alpha;
   logic [8:0]  alpha_sum;
   logic [7:0]  alpha_sat;

   always_comb begin
      src_a     = src_pixel[31:24];
      dst_a     = dst_pixel[31:24];
      ga_inc    = {1'b0, global_alpha} + 9'd1;
      eff_prod  = 16'(src_a) * 16'(ga_inc);
      eff_alpha = (global_alpha != 8'd0) ? eff_prod[15:8] : src_a;
      alpha_sum = {1'b0, src_a} + {1'b0, dst_a};
      alpha_sat = alpha_sum[8] ? 8'hFF : alpha_sum[7:0];

      data_in.kind       = KIND_PASS;
      data_in.pass_pix   = dst_pixel;
      data_in.src_rgb    = src_pixel[23:0];
      data_in.dst_rgb    = dst_pixel[23:0];
      data_in.weight     = 9'd0;
      data_in.dst_weight = (dst_a == 8'd0) ? 9'd0 : {1'b0, dst_a} + 9'd1;
      data_in.mix_alpha  = 8'd0;

      unique case (blend_mode)
         MODE_ARGB_OVER_ARGB: begin
            if (eff_alpha != 8'd0) begin
               data_in.kind   = KIND_CORE;
               data_in.weight = {1'b0, eff_alpha} + 9'd1;
            end
         end
         MODE_RGB_OVER_ARGB: begin
            if (global_alpha == 8'd0 || global_alpha == 8'hFF) begin
               data_in.pass_pix = {8'hFF, src_pixel[23:0]};
            end else begin
               data_in.kind   = KIND_CORE;
               data_in.weight = ga_inc;
            end
         end
         MODE_ARGB_OVER_RGB: begin
            data_in.kind   = KIND_MIX;
            data_in.weight = (eff_alpha != 8'd0) ? {1'b0, eff_alpha} + 9'd1 : 9'd0;
         end
         MODE_TRANS_KEEP_ALPHA: begin
            data_in.kind      = KIND_MIX;
            data_in.weight    = (global_alpha != 8'd0) ? ga_inc : 9'd0;
            data_in.mix_alpha = dst_a;
         end
         MODE_ADD_ALPHA: begin
            data_in.pass_pix = {alpha_sat, src_pixel[23:0]};
         end
         default: begin
            data_in.pass_pix = dst_pixel;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;

endmodule

// File: hw/rtl/argb_blend_mult.sv
`timescale 1ns / 1ps

module argb_blend_mult
   import argb_blend_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   input  logic   advance,
   input  logic   valid_in,
   input  s1_type data_in_s1,
   output logic   valid_out,
   output s2_type data_out
);

   logic        valid_ff;
   s2_type      data_ff;
   s2_type      data_in;
   logic [31:0] op_rb;
   logic [31:0] op_g;
   logic [31:0] factor;
   logic [31:0] prod_rb;
   logic [31:0] prod_g;
   logic [16:0] inv_prod;
   logic [8:0]  fa;

   always_comb begin
      // Core premultiplies the destination by its alpha; mix scales the difference
      if (data_in_s1.kind == KIND_CORE) begin
         op_rb  = 32'(data_in_s1.dst_rgb & 24'hFF00FF);
         op_g   = 32'(data_in_s1.dst_rgb & 24'h00FF00);
         factor = 32'(data_in_s1.dst_weight);
      end else begin
         op_rb  = 32'(data_in_s1.src_rgb & 24'hFF00FF) - 32'(data_in_s1.dst_rgb & 24'hFF00FF);
         op_g   = 32'(data_in_s1.src_rgb & 24'h00FF00) - 32'(data_in_s1.dst_rgb & 24'h00FF00);
         factor = 32'(data_in_s1.weight);
      end
      prod_rb = op_rb * factor;
      prod_g  = op_g * factor;

      inv_prod = 17'(9'd256 - data_in_s1.weight) * 17'(9'd256 - data_in_s1.dst_weight);
      fa       = 9'd256 - {1'b0, inv_prod[15:8]};

      data_in.kind      = data_in_s1.kind;
      data_in.pass_pix  = data_in_s1.pass_pix;
      data_in.src_rgb   = data_in_s1.src_rgb;
      data_in.dst_rgb   = data_in_s1.dst_rgb;
      data_in.weight    = data_in_s1.weight;
      data_in.lane_rb   = prod_rb[31:8];
      data_in.lane_g    = prod_g[23:8];
      // Guard a zero combined alpha as a divisor of one
      data_in.fa_m1     = (fa == 9'd0) ? 8'd0 : 8'(fa - 9'd1);
      data_in.mix_alpha = data_in_s1.mix_alpha;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;

endmodule

// File: hw/rtl/argb_blend_merge.sv
`timescale 1ns / 1ps

module argb_blend_merge
   import argb_blend_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   input  logic   advance,
   input  logic   valid_in,
   input  s2_type data_in_s2,
   output logic   valid_out,
   output s3_type data_out
);

   logic               valid_ff;
   s3_type             data_ff;
   s3_type             data_in;
   logic [RECIP_W-1:0] recip_rom [RECIP_DEPTH];
   logic [31:0]        diff_rb;
   logic [31:0]        diff_g;
   logic [31:0]        prod_rb;
   logic [31:0]        prod_g;
   logic [23:0]        core_rb;
   logic [15:0]        core_g;
   logic [23:0]        mix_rb;
   logic [15:0]        mix_g;

   for (genvar i = 0; i < RECIP_DEPTH; i++) begin : g_recip
      localparam int unsigned RecipValue = RECIP_NUMERATOR / (i + 1);
      assign recip_rom[i] = RECIP_W'(RecipValue);
   end

   always_comb begin
      diff_rb = 32'(data_in_s2.src_rgb & 24'hFF00FF) - 32'(data_in_s2.lane_rb & 24'hFF00FF);
      diff_g  = 32'(data_in_s2.src_rgb & 24'h00FF00) - 32'(data_in_s2.lane_g & 16'hFF00);
      prod_rb = diff_rb * 32'(data_in_s2.weight);
      prod_g  = diff_g * 32'(data_in_s2.weight);
      core_rb = (prod_rb[31:8] + data_in_s2.lane_rb) & 24'hFF00FF;
      core_g  = (prod_g[23:8] + data_in_s2.lane_g) & 16'hFF00;

      // Mix finishes here: add the destination back and place the alpha
      mix_rb = (data_in_s2.lane_rb + data_in_s2.dst_rgb) & 24'hFF00FF;
      mix_g  = (data_in_s2.lane_g + (data_in_s2.dst_rgb[15:0] & 16'hFF00)) & 16'hFF00;

      data_in.kind     = data_in_s2.kind;
      data_in.pass_pix = data_in_s2.pass_pix;
      data_in.rb       = core_rb;
      data_in.g        = core_g;
      data_in.recip    = recip_rom[data_in_s2.fa_m1];
      data_in.fa_m1    = data_in_s2.fa_m1;
      if (data_in_s2.kind == KIND_MIX) begin
         data_in.kind     = KIND_PASS;
         data_in.pass_pix = {data_in_s2.mix_alpha, mix_rb | {8'd0, mix_g}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;

endmodule

// File: hw/rtl/argb_blend_norm.sv
`timescale 1ns / 1ps

module argb_blend_norm
   import argb_blend_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  logic        valid_in,
   input  s3_type      data_in_s3,
   output logic        valid_out,
   output logic [31:0] pixel_out
);

   logic        valid_ff;
   logic [31:0] pixel_ff;
   logic [31:0] pixel_in;
   logic [31:0] prod_rb;
   logic [31:0] prod_g;
   logic [23:0] norm_rb;
   logic [15:0] norm_g;

   always_comb begin
      // Renormalise by the reciprocal of the combined alpha
      prod_rb = 32'(data_in_s3.rb) * 32'(data_in_s3.recip);
      prod_g  = 32'(data_in_s3.g) * 32'(data_in_s3.recip);
      norm_rb = prod_rb[31:8] & 24'hFF00FF;
      norm_g  = prod_g[23:8] & 16'hFF00;
      if (data_in_s3.kind == KIND_CORE) begin
         pixel_in = {data_in_s3.fa_m1, norm_rb | {8'd0, norm_g}};
      end else begin
         pixel_in = data_in_s3.pass_pix;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pixel_ff <= pixel_in;
      end
   end

   assign valid_out = valid_ff;
   assign pixel_out = pixel_ff;

endmodule

// File: hw/rtl/argb_pixel_alpha_blender.sv
`timescale 1ns / 1ps

// ARGB8888 alpha blender.
// req_ carries one source/destination pixel pair per word; rsp_ returns one
// blended pixel per word. csr_ writes blend_mode (index 0) and global_alpha
// (index 1); other indexes are dropped. csr_ready is always high; write
// registers only while no pixel is in flight.
// Four register stages (weight, multiply, lane merge, renormalise and
// output); an accepted word passes through them in that order to rsp_.
// Throughput: one pixel per clock; every stage takes a new word in each
// cycle in which the stage after it moves on.
// A stalled receiver holds the output register; each stage advances when it
// is empty or the stage after it advances, so bubbles close up and req_tready
// drops only once every stage holds a word.
// Reset clears all stage valids and sets blend_mode and global_alpha to zero.
module argb_pixel_alpha_blender
   import argb_blend_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [63:0]            req_tdata,   // src_pixel [31:0], dst_pixel [63:32]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [31:0]            rsp_tdata,   // out_pixel [31:0]
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_wdata
);

   logic [2:0] blend_mode_ff;
   logic [7:0] global_alpha_ff;
   logic       adv1;
   logic       adv2;
   logic       adv3;
   logic       adv4;
   logic       s1_valid;
   logic       s2_valid;
   logic       s3_valid;
   s1_type     s1_data;
   s2_type     s2_data;
   s3_type     s3_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         blend_mode_ff   <= MODE_ARGB_OVER_ARGB;
         global_alpha_ff <= 8'd0;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_BLEND_MODE) begin
            blend_mode_ff <= csr_wdata[2:0];
         end else if (csr_index == CSR_GLOBAL_ALPHA) begin
            global_alpha_ff <= csr_wdata;
         end
      end
   end

   assign adv4       = !rsp_tvalid || rsp_tready;
   assign adv3       = !s3_valid || adv4;
   assign adv2       = !s2_valid || adv3;
   assign adv1       = !s1_valid || adv2;
   assign req_tready = adv1;

   argb_blend_weight u_weight (
      .clock        (clock),
      .reset        (reset),
      .advance      (adv1),
      .valid_in     (req_tvalid),
      .src_pixel    (req_tdata[31:0]),
      .dst_pixel    (req_tdata[63:32]),
      .blend_mode   (blend_mode_ff),
      .global_alpha (global_alpha_ff),
      .valid_out    (s1_valid),
      .data_out     (s1_data)
   );

   argb_blend_mult u_mult (
      .clock      (clock),
      .reset      (reset),
      .advance    (adv2),
      .valid_in   (s1_valid),
      .data_in_s1 (s1_data),
      .valid_out  (s2_valid),
      .data_out   (s2_data)
   );

   argb_blend_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .advance    (adv3),
      .valid_in   (s2_valid),
      .data_in_s2 (s2_data),
      .valid_out  (s3_valid),
      .data_out   (s3_data)
   );

   argb_blend_norm u_norm (
      .clock      (clock),
      .reset      (reset),
      .advance    (adv4),
      .valid_in   (s3_valid),
      .data_in_s3 (s3_data),
      .valid_out  (rsp_tvalid),
      .pixel_out  (rsp_tdata)
   );

   // An accepted word lands in the first stage
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> s1_valid)
      else $error("accepted word missing from first stage");

   // A full pipe behind a stalled output takes nothing new
   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      s1_valid && s2_valid && s3_valid && rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input taken while pipe is full and stalled");

   // Mix words are resolved before the last stage
   a_mix_resolved: assert property (@(posedge clock) disable iff (reset)
      s3_valid |-> s3_data.kind != KIND_MIX)
      else $error("unresolved mix word in last stage");

   // A stalled merge stage holds its word
   a_hold_stage: assert property (@(posedge clock) disable iff (reset)
      s3_valid && !adv3 |=> s3_valid && $stable(s3_data))
      else $error("stalled merge stage changed");

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import argb_blend_pkg::*;

   localparam int ALPHA_SHIFT = 24;
   localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
   localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;
   localparam int CSR_INDEX_MAX = (1 << CSR_INDEX_W) - 1;

   class blend_scoreboard;
      bit [2:0]  blend_mode;
      bit [7:0]  global_alpha;
      bit [31:0] expected_pixels[$];
      int        errors;

      function void write_reg(bit [CSR_INDEX_W-1:0] index, bit [7:0] data);
         if (index == CSR_BLEND_MODE) begin
            blend_mode = data[2:0];
         end else if (index == CSR_GLOBAL_ALPHA) begin
            global_alpha = data;
         end
      endfunction

      function bit [31:0] alpha_of(bit [31:0] p);
         return (p >> ALPHA_SHIFT) & 32'hFF;
      endfunction

      function bit [31:0] scaled_alpha(bit [31:0] src);
         bit [31:0] ga;
         ga = {24'd0, global_alpha};
         if (ga != 0) return (alpha_of(src) * (ga + 32'd1)) >> 8;
         return alpha_of(src);
      endfunction

      // combined-alpha blend, then renormalise the colour by 0x10000 / alpha
      function bit [31:0] combine(bit [31:0] src, bit [31:0] dst, bit [31:0] wa);
         bit [31:0] sa, da, g, rb, fa, recip;
         sa = wa + 32'd1;
         da = alpha_of(dst);
         if (da != 0) da = da + 32'd1;
         g  = ((dst & 32'h00FF00) * da) >> 8;
         rb = ((dst & 32'hFF00FF) * da) >> 8;
         g  = (((((src & 32'h00FF00) - (g & 32'h00FF00)) * sa) >> 8) + g) & 32'h00FF00;
         rb = (((((src & 32'hFF00FF) - (rb & 32'hFF00FF)) * sa) >> 8) + rb) & 32'hFF00FF;
         fa = 32'd256 - (((32'd256 - sa) * (32'd256 - da)) >> 8);
         if (fa == 0) fa = 32'd1;
         recip = 32'h10000 / fa;
         g  = ((g * recip) >> 8) & 32'h00FF00;
         rb = ((rb * recip) >> 8) & 32'hFF00FF;
         return rb | g | (((fa - 32'd1) & 32'hFF) << 24);
      endfunction

      function bit [31:0] mix(bit [31:0] src, bit [31:0] dst, bit [31:0] w);
         bit [31:0] rb, g;
         rb = ((((src & 32'hFF00FF) - (dst & 32'hFF00FF)) * w) >> 8) + dst;
         g  = ((((src & 32'h00FF00) - (dst & 32'h00FF00)) * w) >> 8) + (dst & 32'h00FF00);
         return (rb & 32'hFF00FF) | (g & 32'h00FF00);
      endfunction

      function bit [31:0] blend_pixel(bit [31:0] src, bit [31:0] dst);
         bit [31:0] a, sum;
         case (blend_mode)
            MODE_ARGB_OVER_ARGB: begin
               a = scaled_alpha(src);
               if (a == 0) return dst;
               return combine(src, dst, a);
            end
            MODE_RGB_OVER_ARGB: begin
               if (global_alpha == 8'h00 || global_alpha == 8'hFF) return src | 32'hFF000000;
               return combine(src | 32'hFF000000, dst, {24'd0, global_alpha});
            end
            MODE_ARGB_OVER_RGB: begin
               a = scaled_alpha(src);
               if (a != 0) a = a + 32'd1;
               return mix(src, dst, a);
            end
            MODE_TRANS_KEEP_ALPHA: begin
               a = {24'd0, global_alpha};
               if (a != 0) a = a + 32'd1;
               return mix(src, dst & 32'h00FFFFFF, a) | (dst & 32'hFF000000);
            end
            MODE_ADD_ALPHA: begin
               sum = (src >> 24) + (dst >> 24);
               if (sum > 32'hFF) sum = 32'hFF;
               return (sum << 24) | (src & 32'h00FFFFFF);
            end
            default: return dst;
         endcase
      endfunction

      function void note_pair(bit [31:0] src, bit [31:0] dst);
         expected_pixels.push_back(blend_pixel(src, dst));
      endfunction

      function void check_pixel(bit [31:0] actual);
         bit [31:0] want;
         if (expected_pixels.size() == 0) begin
            $display("%0t: unexpected out_pixel, expected none, actual %08h", $time, actual);
            errors++;
         end else begin
            want = expected_pixels.pop_front();
            if (want !== actual) begin
               $display("%0t: out_pixel mismatch, expected %08h, actual %08h",
                        $time, want, actual);
               errors++;
            end
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [63:0]            req_tdata = '0;   // src_pixel [31:0], dst_pixel [63:32]
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [31:0]            rsp_tdata;        // out_pixel [31:0]
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [7:0]             csr_wdata = '0;

   blend_scoreboard sb;
   int send_idle_pct = 30;
   int recv_idle_pct = 61;
   int hold_left = 0;
   bit stall_request = 1'b0;

   argb_pixel_alpha_blender DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // receiver: random back-pressure, or a long hold-off when asked
   always @(negedge clock) begin
      if (stall_request) begin
         hold_left = 80;
         stall_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_pair(req_tdata[31:0], req_tdata[63:32]);
         if (rsp_tvalid && rsp_tready) sb.check_pixel(rsp_tdata);
      end
   end

   task automatic push_pixels(input bit [31:0] src, input bit [31:0] dst);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {dst, src};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic csr_put(input bit [CSR_INDEX_W-1:0] index, input bit [7:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(index, data);
      @(negedge clock);
   endtask

   // drain the pipe, then rewrite both registers and, if asked, poke a spare index
   task automatic set_blend(input bit [2:0] mode, input bit [7:0] alpha, input bit poke_spare);
      bit [4:0] junk;
      junk = 5'($urandom_range(31));
      req_tvalid <= 1'b0;
      while (sb.expected_pixels.size() != 0) @(posedge clock);
      @(negedge clock);
      csr_put(CSR_BLEND_MODE, {junk, mode});
      csr_put(CSR_GLOBAL_ALPHA, alpha);
      if (poke_spare) begin
         csr_put(CSR_INDEX_W'($urandom_range(CSR_GLOBAL_ALPHA + 1, CSR_INDEX_MAX)),
                 8'($urandom()));
      end
      csr_valid <= 1'b0;
   endtask

   task automatic run_case(input bit [2:0] mode, input bit [7:0] alpha,
                           input bit [31:0] src, input bit [31:0] dst);
      if (mode != sb.blend_mode || alpha != sb.global_alpha) set_blend(mode, alpha, 1'b1);
      push_pixels(src, dst);
   endtask

   function automatic bit [31:0] pick_pixel();
      bit [31:0] p;
      p = $urandom();
      case ($urandom_range(5))
         0: p[31:24] = 8'h00;
         1: p[31:24] = 8'hFF;
         2: p[31:24] = 8'h01;
         3: p[31:24] = 8'hFE;
         default: ;
      endcase
      if ($urandom_range(9) == 0) p[23:0] = $urandom_range(1) ? 24'hFFFFFF : 24'h000000;
      return p;
   endfunction

   initial begin
      bit [2:0] mode;
      bit [7:0] alpha;
      sb = new;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed corners, starting from the reset settings
      run_case(MODE_ARGB_OVER_ARGB, 8'd0, 32'h00123456, 32'h89ABCDEF);
      run_case(MODE_ARGB_OVER_ARGB, 8'd0, 32'hFFFFFFFF, 32'h00000000);
      run_case(MODE_ARGB_OVER_ARGB, 8'd0, 32'h80FF8040, 32'hFF102030);
      run_case(MODE_ARGB_OVER_ARGB, 8'd0, 32'h00000000, 32'hFFFFFFFF);
      run_case(MODE_ARGB_OVER_ARGB, 8'd1, 32'h01FFFFFF, 32'h7F808080);
      run_case(MODE_ARGB_OVER_ARGB, 8'd1, 32'hFF00FF00, 32'h80FF00FF);
      run_case(MODE_ARGB_OVER_ARGB, 8'd255, 32'h40C0C0C0, 32'h40404040);
      run_case(MODE_RGB_OVER_ARGB, 8'd0, 32'h12345678, 32'h9ABCDEF0);
      run_case(MODE_RGB_OVER_ARGB, 8'd255, 32'h00000000, 32'hFFFFFFFF);
      run_case(MODE_RGB_OVER_ARGB, 8'd128, 32'h00FF00FF, 32'h00000000);
      run_case(MODE_RGB_OVER_ARGB, 8'd128, 32'h7F102030, 32'hFFEEDDCC);
      run_case(MODE_ARGB_OVER_RGB, 8'd0, 32'h00FFFFFF, 32'hFF000000);
      run_case(MODE_ARGB_OVER_RGB, 8'd0, 32'hFFFFFFFF, 32'h00000000);
      run_case(MODE_ARGB_OVER_RGB, 8'd200, 32'h80804020, 32'h12345678);
      run_case(MODE_TRANS_KEEP_ALPHA, 8'd0, 32'hFFFFFFFF, 32'h80000000);
      run_case(MODE_TRANS_KEEP_ALPHA, 8'd255, 32'h00ABCDEF, 32'hFF123456);
      run_case(MODE_TRANS_KEEP_ALPHA, 8'd77, 32'h5A5A5A5A, 32'hA5A5A5A5);
      run_case(MODE_ADD_ALPHA, 8'd0, 32'hFF000000, 32'hFF000000);
      run_case(MODE_ADD_ALPHA, 8'd0, 32'h10FFFFFF, 32'h20000000);
      run_case(MODE_ADD_ALPHA, 8'd0, 32'h00000000, 32'h00FFFFFF);
      for (int m = MODE_SPARE_FIRST; m <= MODE_SPARE_LAST; m++) begin
         run_case(m[2:0], 8'd9, 32'hFFFFFFFF, 32'h13579BDF);
      end

      // random segments: receiver-heavy idling, then sender-heavy, then none
      for (int seg = 0; seg < 15; seg++) begin
         case (seg / 5)
            0: begin send_idle_pct = 30; recv_idle_pct = 61; end
            1: begin send_idle_pct = 61; recv_idle_pct = 30; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         mode = (seg < 10) ? 3'(seg % 5) : 3'($urandom_range(7));
         case ($urandom_range(5))
            0: alpha = 8'd0;
            1: alpha = 8'd255;
            2: alpha = 8'd1;
            3: alpha = 8'd254;
            default: alpha = 8'($urandom_range(255));
         endcase
         set_blend(mode, alpha, $urandom_range(1));
         // hold the receiver off while words keep coming, to fill the pipe
         if (seg == 10) stall_request = 1'b1;
         repeat (100) push_pixels(pick_pixel(), pick_pixel());
      end

      req_tvalid <= 1'b0;
      while (sb.expected_pixels.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.errors == 0) begin
         $display("argb_pixel_alpha_blender regression: pass");
      end else begin
         $display("argb_pixel_alpha_blender regression: fail");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("argb_pixel_alpha_blender regression: fail");
      $finish;
   end

endmodule

// File: files.f
hw/rtl/argb_blend_pkg.sv
hw/rtl/argb_blend_weight.sv
hw/rtl/argb_blend_mult.sv
hw/rtl/argb_blend_merge.sv
hw/rtl/argb_blend_norm.sv
hw/rtl/argb_pixel_alpha_blender.sv
sim/testbench.sv
